@@ rtl/ffha_pkg.sv @@
// Package for the first-fit heap allocator: sizes, codes, header helpers and microcode ROM.
package ffha_pkg;

  localparam int HEAP_SIZE  = 4096;
  localparam int HDR_BYTES  = 2;
  localparam int HDR_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = $clog2(HEAP_SIZE);
  localparam int BANK_W     = ADDR_W - 1;
  localparam int BANK_DEPTH = HEAP_SIZE / 2;
  localparam int FIELD_W    = 12;
  localparam int STATUS_W   = 3;
  localparam int UCODE_LEN  = 43;
  localparam int STEP_W     = $clog2(UCODE_LEN);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ADDR_W:0]   addr_x_t;
  typedef logic [HDR_W-1:0]  hdr_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam addr_x_t HDR_X      = addr_x_t'(HDR_BYTES);
  localparam addr_x_t LAST_HDR_X = addr_x_t'(HEAP_SIZE - HDR_BYTES);
  localparam hdr_t    HDR_RESET  = hdr_t'(HEAP_SIZE - HDR_BYTES);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_BAD_PTR      = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  // Datapath action of one microcode step.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PTR0,
    ACT_INIT_REL,
    ACT_RD_CUR,
    ACT_RD_NXT,
    ACT_LD_CUR,
    ACT_LD_NXT,
    ACT_WR_MERGE,
    ACT_WR_FREE,
    ACT_WR_SPLIT,
    ACT_WR_USED,
    ACT_ADVANCE,
    ACT_SHIFT
  } act_e;

  // Jump condition of one microcode step; no jump means fall through.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_OP_REL,
    C_BAD_SIZE,
    C_CUR_USED,
    C_CUR_FREE,
    C_CUR_LAST,
    C_NXT_USED,
    C_EITHER_USED,
    C_NO_FIT,
    C_NO_SPLIT,
    C_BAD_OFF,
    C_WALK_DONE,
    C_PTR_NE_TGT
  } cond_e;

  typedef struct packed {
    act_e    act;
    cond_e   cond;
    step_t   tgt;
    logic    fin;
    logic    res;
    status_e st;
  } ucode_t;

  // Jump targets.
  localparam step_t U_IDLE     = step_t'(0);
  localparam step_t U_A_LOOP   = step_t'(3);
  localparam step_t U_A_FIT    = step_t'(11);
  localparam step_t U_A_MARK   = step_t'(14);
  localparam step_t U_A_STEP   = step_t'(15);
  localparam step_t U_A_NOSPC  = step_t'(17);
  localparam step_t U_A_BADSZ  = step_t'(18);
  localparam step_t U_REL      = step_t'(19);
  localparam step_t U_R_WALK   = step_t'(20);
  localparam step_t U_R_CHK    = step_t'(24);
  localparam step_t U_R_COAL   = step_t'(31);
  localparam step_t U_R_CL     = step_t'(34);
  localparam step_t U_R_SHIFT  = step_t'(39);
  localparam step_t U_R_OK     = step_t'(40);
  localparam step_t U_R_BADPTR = step_t'(41);
  localparam step_t U_R_AFREE  = step_t'(42);

  localparam ucode_t UCODE [UCODE_LEN] = '{
    // 0 idle: wait for a request word
    '{ACT_NONE,     C_NO_IN,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_OP_REL,      U_REL,      1'b0, 1'b0, ST_OK},
    // 2 allocate
    '{ACT_PTR0,     C_BAD_SIZE,    U_A_BADSZ,  1'b0, 1'b0, ST_OK},
    '{ACT_RD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_CUR_USED,    U_A_STEP,   1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_CUR_LAST,    U_A_FIT,    1'b0, 1'b0, ST_OK},
    '{ACT_RD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_NXT_USED,    U_A_FIT,    1'b0, 1'b0, ST_OK},
    '{ACT_WR_MERGE, C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    // 11 fit test
    '{ACT_NONE,     C_NO_FIT,      U_A_STEP,   1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_NO_SPLIT,    U_A_MARK,   1'b0, 1'b0, ST_OK},
    '{ACT_WR_SPLIT, C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_WR_USED,  C_ALWAYS,      U_IDLE,     1'b1, 1'b1, ST_OK},
    // 15 step to next block
    '{ACT_NONE,     C_CUR_LAST,    U_A_NOSPC,  1'b0, 1'b0, ST_OK},
    '{ACT_ADVANCE,  C_ALWAYS,      U_A_LOOP,   1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_ALWAYS,      U_IDLE,     1'b1, 1'b0, ST_NO_SPACE},
    '{ACT_NONE,     C_ALWAYS,      U_IDLE,     1'b1, 1'b0, ST_BAD_SIZE},
    // 19 release: walk the chain up to the target header
    '{ACT_INIT_REL, C_BAD_OFF,     U_R_BADPTR, 1'b0, 1'b0, ST_OK},
    '{ACT_RD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_WALK_DONE,   U_R_CHK,    1'b0, 1'b0, ST_OK},
    '{ACT_ADVANCE,  C_ALWAYS,      U_R_WALK,   1'b0, 1'b0, ST_OK},
    // 24 check and free, merge forward
    '{ACT_NONE,     C_PTR_NE_TGT,  U_R_BADPTR, 1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_CUR_FREE,    U_R_AFREE,  1'b0, 1'b0, ST_OK},
    '{ACT_WR_FREE,  C_CUR_LAST,    U_R_COAL,   1'b0, 1'b0, ST_OK},
    '{ACT_RD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_NXT_USED,    U_R_COAL,   1'b0, 1'b0, ST_OK},
    '{ACT_WR_MERGE, C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    // 31 coalesce the whole heap
    '{ACT_PTR0,     C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_RD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_CUR,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_CUR_LAST,    U_R_OK,     1'b0, 1'b0, ST_OK},
    '{ACT_RD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_LD_NXT,   C_NEVER,       U_IDLE,     1'b0, 1'b0, ST_OK},
    '{ACT_NONE,     C_EITHER_USED, U_R_SHIFT,  1'b0, 1'b0, ST_OK},
    '{ACT_WR_MERGE, C_ALWAYS,      U_R_CL,     1'b0, 1'b0, ST_OK},
    '{ACT_SHIFT,    C_ALWAYS,      U_R_CL,     1'b0, 1'b0, ST_OK},
    // 40 finish
    '{ACT_NONE,     C_ALWAYS,      U_IDLE,     1'b1, 1'b0, ST_OK},
    '{ACT_NONE,     C_ALWAYS,      U_IDLE,     1'b1, 1'b0, ST_BAD_PTR},
    '{ACT_NONE,     C_ALWAYS,      U_IDLE,     1'b1, 1'b0, ST_ALREADY_FREE}
  };

  function automatic addr_t hdr_len(hdr_t v);
    hdr_t a;
    a = v[HDR_W-1] ? hdr_t'(-v) : v;
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic hdr_free(hdr_t v);
    return !v[HDR_W-1];
  endfunction

  function automatic hdr_t hdr_pack(addr_t len, logic used);
    hdr_t w;
    w = hdr_t'(len);
    return used ? hdr_t'(-w) : w;
  endfunction

endpackage

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator: microcoded sequencer over a byte heap held in two byte banks.
// Allocate walks the chain, merging a free block with a free successor, up to the block
//   taken; release walks to the target header, frees it, merges it forward, then runs a
//   coalesce pass over the whole heap before it finishes.
// Throughput: one request word at a time; the single heap memory port sets the pace.
// Reset: the heap holds one free block at once; a flag stands in for header zero until
//   its first write, so no clearing pass runs after reset.
module first_fit_heap_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [ffha_pkg::FIELD_W-1:0]   req_bytes_i,
  input  logic [ffha_pkg::FIELD_W-1:0]   payload_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  output logic [ffha_pkg::FIELD_W-1:0]   result_offset_o
);
  import ffha_pkg::*;

  // sequencer
  step_t   step_q;
  step_t   step_d;
  ucode_t  u;
  logic    go;
  logic    jump;
  logic    in_accept;

  // request word
  logic    op_q;
  addr_t   req_q;
  addr_t   off_q;

  // datapath: current block, next block, release target
  addr_t   ptr_q;
  addr_t   tgt_q;
  addr_t   clen_q;
  logic    cfree_q;
  addr_t   nlen_q;
  logic    nfree_q;
  addr_x_t nxt_x;
  addr_x_t merged_x;
  addr_x_t split_x;
  addr_x_t remain_x;
  addr_x_t need_x;
  logic    cur_last;

  // output register
  logic    out_valid_q;
  status_e status_q;
  addr_t   result_q;

  // heap memory, split into even and odd byte banks so a header reads in one access
  logic [BYTE_W-1:0] ev_mem [BANK_DEPTH];
  logic [BYTE_W-1:0] od_mem [BANK_DEPTH];
  logic [BYTE_W-1:0] ev_rd_q;
  logic [BYTE_W-1:0] od_rd_q;
  logic [BYTE_W-1:0] ev_wbyte;
  logic [BYTE_W-1:0] od_wbyte;
  logic [BANK_W-1:0] ev_idx;
  logic [BANK_W-1:0] od_idx;
  addr_t             mem_addr;
  hdr_t              mem_wdata;
  logic              mem_re;
  logic              mem_we;
  logic              rd_par_q;
  logic              rd_zero_q;
  logic              hdr0_wr_q;
  hdr_t              rd_hdr;

  assign u = UCODE[step_q];

  // Hold a finishing step while the previous result word still waits downstream.
  assign go = !(u.fin && out_valid_q && out_stall_i);

  assign in_stall_o = (step_q != U_IDLE);
  assign in_accept  = in_valid_i && (step_q == U_IDLE);

  // Block arithmetic: successor header, merged length, split point and remainder.
  assign nxt_x    = {1'b0, ptr_q} + HDR_X + {1'b0, clen_q};
  assign cur_last = (nxt_x > LAST_HDR_X);
  assign merged_x = {1'b0, clen_q} + HDR_X + {1'b0, nlen_q};
  assign split_x  = {1'b0, ptr_q} + HDR_X + {1'b0, req_q};
  assign remain_x = {1'b0, clen_q} - {1'b0, req_q} - HDR_X;
  assign need_x   = {1'b0, req_q} + HDR_X + addr_x_t'(1);

  // Evaluate the jump condition on the registers as they stand before this step.
  always_comb begin
    unique case (u.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_IN:       jump = !in_valid_i;
      C_OP_REL:      jump = op_q;
      C_BAD_SIZE:    jump = (req_q == '0) || ({1'b0, req_q} > LAST_HDR_X);
      C_CUR_USED:    jump = !cfree_q;
      C_CUR_FREE:    jump = cfree_q;
      C_CUR_LAST:    jump = cur_last;
      C_NXT_USED:    jump = !nfree_q;
      C_EITHER_USED: jump = !cfree_q || !nfree_q;
      C_NO_FIT:      jump = (clen_q < req_q);
      C_NO_SPLIT:    jump = ({1'b0, clen_q} < need_x);
      C_BAD_OFF:     jump = ({1'b0, off_q} < HDR_X);
      C_WALK_DONE:   jump = !((ptr_q < tgt_q) && !cur_last);
      C_PTR_NE_TGT:  jump = (ptr_q != tgt_q);
      default:       jump = 1'b0;
    endcase
  end

  assign step_d = jump ? u.tgt : step_t'(step_q + step_t'(1));

  // Memory port: address, write data and enables from the action field.
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ptr_q;
    mem_wdata = '0;
    unique case (u.act)
      ACT_RD_CUR: mem_re = go;
      ACT_RD_NXT: begin
        mem_re   = go;
        mem_addr = nxt_x[ADDR_W-1:0];
      end
      ACT_WR_MERGE: begin
        mem_we    = go;
        mem_wdata = hdr_pack(merged_x[ADDR_W-1:0], 1'b0);
      end
      ACT_WR_FREE: begin
        mem_we    = go;
        mem_wdata = hdr_pack(clen_q, 1'b0);
      end
      ACT_WR_SPLIT: begin
        mem_we    = go;
        mem_addr  = split_x[ADDR_W-1:0];
        mem_wdata = hdr_pack(remain_x[ADDR_W-1:0], 1'b0);
      end
      ACT_WR_USED: begin
        mem_we    = go;
        mem_wdata = hdr_pack(clen_q, 1'b1);
      end
      default: ;
    endcase
  end

  // Low byte sits at the header offset, high byte right after it; an odd offset
  // puts the high byte in the next even slot.
  assign od_idx   = mem_addr[ADDR_W-1:1];
  assign ev_idx   = mem_addr[ADDR_W-1:1] + BANK_W'(mem_addr[0]);
  assign ev_wbyte = mem_addr[0] ? mem_wdata[HDR_W-1:BYTE_W] : mem_wdata[BYTE_W-1:0];
  assign od_wbyte = mem_addr[0] ? mem_wdata[BYTE_W-1:0] : mem_wdata[HDR_W-1:BYTE_W];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ev_mem[ev_idx] <= ev_wbyte;
    end
    if (mem_re) begin
      ev_rd_q <= ev_mem[ev_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      od_mem[od_idx] <= od_wbyte;
    end
    if (mem_re) begin
      od_rd_q <= od_mem[od_idx];
    end
  end

  // Header zero reads as the whole free heap until its first write.
  assign rd_hdr = rd_zero_q ? HDR_RESET :
                  (rd_par_q ? {ev_rd_q, od_rd_q} : {od_rd_q, ev_rd_q});

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_i;
      req_q <= addr_t'(req_bytes_i);
      off_q <= addr_t'(payload_offset_i);
    end
    if (mem_re) begin
      rd_par_q  <= mem_addr[0];
      rd_zero_q <= (mem_addr == '0) && !hdr0_wr_q;
    end
    if (go) begin
      unique case (u.act)
        ACT_PTR0: ptr_q <= '0;
        ACT_INIT_REL: begin
          ptr_q <= '0;
          tgt_q <= addr_t'({1'b0, off_q} - HDR_X);
        end
        ACT_LD_CUR: begin
          clen_q  <= hdr_len(rd_hdr);
          cfree_q <= hdr_free(rd_hdr);
        end
        ACT_LD_NXT: begin
          nlen_q  <= hdr_len(rd_hdr);
          nfree_q <= hdr_free(rd_hdr);
        end
        ACT_WR_MERGE: clen_q  <= merged_x[ADDR_W-1:0];
        ACT_WR_FREE:  cfree_q <= 1'b1;
        ACT_WR_SPLIT: clen_q  <= req_q;
        ACT_ADVANCE:  ptr_q   <= nxt_x[ADDR_W-1:0];
        // Step to the successor already in hand: no reread needed.
        ACT_SHIFT: begin
          ptr_q   <= nxt_x[ADDR_W-1:0];
          clen_q  <= nlen_q;
          cfree_q <= nfree_q;
        end
        default: ;
      endcase
      if (u.fin) begin
        status_q <= u.st;
        result_q <= u.res ? addr_t'({1'b0, ptr_q} + HDR_X) : '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= U_IDLE;
      out_valid_q <= 1'b0;
      hdr0_wr_q   <= 1'b0;
    end else begin
      if (go) begin
        step_q <= step_d;
      end
      if (go && u.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we && (mem_addr == '0)) begin
        hdr0_wr_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_offset_o = FIELD_W'(result_q);

  // A failed or release word always carries offset zero.
  a_res_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (result_offset_o == '0))
    else $error("nonzero offset on a word without ok status");

  // Every heap access stays where a whole header fits.
  a_mem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re || mem_we) |-> ({1'b0, mem_addr} <= LAST_HDR_X))
    else $error("heap access beyond the last header slot");

  // Merge only two free blocks.
  a_merge_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (u.act == ACT_WR_MERGE) |-> (cfree_q && nfree_q))
    else $error("merge of a used block");

endmodule

@@ tb/sv/first_fit_heap_allocator_tb.sv @@
// Self-checking testbench for the first-fit heap allocator: directed and random requests.
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  // Request opcodes carried on op_i.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam int RANDOM_WORDS = 850;
  // Worst case: ~1365 blocks walked per word, plus both idle gaps.
  localparam int unsigned CYCLE_LIMIT = 50_000_000;
  localparam int HOLD_START  = 300;   // accepted words before the long output hold-off
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic                op;
    logic [FIELD_W-1:0]  req;
    logic [FIELD_W-1:0]  off;
  } req_word_t;

  typedef struct {
    status_e             status;
    logic [FIELD_W-1:0]  offset;
  } reply_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_op    = OP_ALLOC;
  logic [FIELD_W-1:0]  in_req   = '0;
  logic [FIELD_W-1:0]  in_off   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  result_offset_o;

  // Handshake flags, set at the rising edge and read on the falling edge.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  req_word_t          stim_q[$];    // words waiting for the driver
  reply_t             reply_q[$];   // predicted replies, oldest first
  logic [FIELD_W-1:0] live_q[$];    // payload offsets the model holds as allocated
  logic [FIELD_W-1:0] freed_q[$];   // recently released offsets, for double frees

  int          err_cnt      = 0;
  int          accepted_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int          gap_left     = 0;
  int          drv_burst    = 0;
  int          sink_wait    = 0;
  int          sink_burst   = 0;
  int          hold_left    = 0;
  logic        hold_done    = 1'b0;

  first_fit_heap_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .op_i             (in_op),
    .req_bytes_i      (in_req),
    .payload_offset_i (in_off),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .status_o         (status_o),
    .result_offset_o  (result_offset_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Heap model: a byte image with 2-byte little-endian signed headers.
  // A negative header marks a used block; its magnitude is the payload length.
  // ---------------------------------------------------------------------------
  logic [7:0] heap_mem [HEAP_SIZE];

  function automatic int hdr_get(int h);
    if (h > HEAP_SIZE - HDR_BYTES) return 0;
    return int'(shortint'({heap_mem[h+1], heap_mem[h]}));
  endfunction

  function automatic void hdr_put(int h, int v);
    if (h > HEAP_SIZE - HDR_BYTES) return;
    {heap_mem[h+1], heap_mem[h]} = v[15:0];
  endfunction

  function automatic int blk_size(int h);
    int v;
    v = hdr_get(h);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit blk_open(int h);
    return hdr_get(h) >= 0;
  endfunction

  function automatic int blk_after(int h);
    return h + HDR_BYTES + blk_size(h);
  endfunction

  // Tail block: no room for another header behind it.
  function automatic bit blk_tail(int h);
    return blk_after(h) > HEAP_SIZE - HDR_BYTES;
  endfunction

  // Absorb the successor of free block h into h.
  function automatic void fuse(int h);
    int n;
    n = blk_after(h);
    hdr_put(h, blk_size(h) + HDR_BYTES + blk_size(n));
  endfunction

  // Collapse every run of adjacent free blocks; the merged block stays put
  // as predecessor so a whole run folds into one.
  function automatic void merge_runs();
    int p;
    p = 0;
    while (!blk_tail(p)) begin
      if (blk_open(p) && blk_open(blk_after(p))) fuse(p);
      else p = blk_after(p);
    end
  endfunction

  function automatic status_e heap_alloc(int size, output int where);
    int cur;
    int len;
    bit found;
    bit stop;
    where = 0;
    cur   = 0;
    found = 1'b0;
    stop  = 1'b0;
    if (size == 0 || size > HEAP_SIZE - HDR_BYTES) return ST_BAD_SIZE;
    // First fit; merge with a free successor once per visit, then resume
    // the walk behind the merged block.
    while (!stop) begin
      if (blk_open(cur)) begin
        if (!blk_tail(cur) && blk_open(blk_after(cur))) fuse(cur);
        if (blk_size(cur) >= size) found = 1'b1;
      end
      if (found || blk_tail(cur)) stop = 1'b1;
      else cur = blk_after(cur);
    end
    if (!found) return ST_NO_SPACE;
    len = blk_size(cur);
    // Split only when a header plus at least one byte remains.
    if (len >= size + HDR_BYTES + 1) begin
      hdr_put(cur + HDR_BYTES + size, len - size - HDR_BYTES);
      len = size;
    end
    hdr_put(cur, -len);
    where = cur + HDR_BYTES;
    return ST_OK;
  endfunction

  function automatic status_e heap_release(int off);
    int h;
    int p;
    if (off < HDR_BYTES || off > HEAP_SIZE - 1) return ST_BAD_PTR;
    h = off - HDR_BYTES;
    p = 0;
    while (p < h && !blk_tail(p)) p = blk_after(p);
    // The header must sit on the block chain; otherwise leave the heap alone.
    if (p != h) return ST_BAD_PTR;
    if (blk_open(h)) return ST_ALREADY_FREE;
    hdr_put(h, blk_size(h));
    if (!blk_tail(h) && blk_open(blk_after(h))) fuse(h);
    merge_runs();
    return ST_OK;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. The field an op does not use gets random content.
  // ---------------------------------------------------------------------------
  function automatic void push_alloc(int bytes);
    req_word_t w;
    w.op  = OP_ALLOC;
    w.req = bytes[FIELD_W-1:0];
    w.off = FIELD_W'($urandom_range(0, 4095));
    stim_q.push_back(w);
  endfunction

  function automatic void push_release(int off);
    req_word_t w;
    w.op  = OP_RELEASE;
    w.req = FIELD_W'($urandom_range(0, 4095));
    w.off = off[FIELD_W-1:0];
    stim_q.push_back(w);
  endfunction

  // Mostly small blocks keep the chain short; a few large ones force no-space.
  function automatic int draw_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 32);
    if (r < 92) return $urandom_range(33, 256);
    if (r < 98) return $urandom_range(257, 1024);
    return $urandom_range(1025, HEAP_SIZE - HDR_BYTES);
  endfunction

  // Idle cycles before the next word; bursts of back-to-back words in between.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst = burst - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present request words on the falling edge, hold a stalled word.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    req_word_t w;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        w = stim_q.pop_front();
        in_op    <= w.op;
        in_req   <= w.req;
        in_off   <= w.off;
        in_valid <= 1'b1;
        gap_left = draw_wait(drv_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stall a random number of cycles per reply word.
  always @(negedge clk_i) begin : sink
    if (out_fire) sink_wait = draw_wait(sink_burst);
    else if (out_valid_o === 1'b1 && sink_wait > 0) sink_wait = sink_wait - 1;
    out_stall <= (hold_left != 0) || (sink_wait > 0);
  end

  // One long output hold-off while the driver keeps offering words, so the
  // block backs up and stalls its request side.
  always @(negedge clk_i) begin : hold_off
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_START) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check reply words against the oldest prediction, then predict
  // the reply of any request word accepted at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    reply_t want;
    int     where;
    int     hit;
    logic   take_in;
    logic   take_out;
    take_in  = rst_ni && in_valid && (in_stall_o === 1'b0);
    take_out = rst_ni && (out_valid_o === 1'b1) && !out_stall;
    in_fire  <= take_in;
    out_fire <= take_out;
    if (take_out) begin
      if (reply_q.size() == 0) begin
        $error("reply word with no request pending: status %0d, result_offset %0d",
               status_o, result_offset_o);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          err_cnt++;
        end
        if (result_offset_o !== want.offset) begin
          $error("result_offset: expected %0d, actual %0d", want.offset, result_offset_o);
          err_cnt++;
        end
      end
    end
    if (take_in) begin
      accepted_cnt++;
      if (in_op == OP_ALLOC) begin
        want.status = heap_alloc(int'(in_req), where);
        want.offset = where[FIELD_W-1:0];
        if (want.status == ST_OK) live_q.push_back(want.offset);
      end else begin
        want.status = heap_release(int'(in_off));
        want.offset = '0;
        if (want.status == ST_OK) begin
          // Drop the offset from the live set and remember it for double frees.
          hit = -1;
          foreach (live_q[k]) if (live_q[k] == in_off) hit = k;
          if (hit >= 0) live_q.delete(hit);
          freed_q.push_back(in_off);
          if (freed_q.size() > 8) void'(freed_q.pop_front());
        end
      end
      reply_q.push_back(want);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed words, random words, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int pick;
    int n;
    foreach (heap_mem[k]) heap_mem[k] = 8'h00;
    hdr_put(0, HEAP_SIZE - HDR_BYTES);

    // Size limits: zero, above heap minus header, and the whole heap.
    push_alloc(0);
    push_alloc(4095);
    push_alloc(HEAP_SIZE - HDR_BYTES);
    push_alloc(1);                        // heap full: no space
    // Pointers below the first payload and past the chain.
    push_release(0);
    push_release(1);
    push_release(4095);
    push_release(HDR_BYTES);
    push_release(HDR_BYTES);              // double free
    // Split that leaves exactly a header plus one byte, then use that byte.
    push_alloc(HEAP_SIZE - HDR_BYTES - 3);
    push_alloc(1);                        // payload at the last heap byte
    push_release(4095);
    push_release(HDR_BYTES);
    // Three neighbors; free the middle one, probe inside a block.
    push_alloc(10);
    push_alloc(10);
    push_alloc(10);
    push_release(15);                     // not on the chain
    push_release(14);
    push_alloc(11);                       // skips the too-small hole
    push_release(HDR_BYTES);              // coalesces with the freed neighbor
    push_alloc(3);                        // split the merged hole
    push_release(4094);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Keep a couple of words queued so release targets track live blocks.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      while (stim_q.size() >= 2) @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (live_q.size() > 48 && pick < 60) pick = 50;   // drain a crowded heap
      if (pick < 46 || (pick < 81 && live_q.size() == 0)) begin
        push_alloc(draw_size());
      end else if (pick < 81) begin
        push_release(live_q[$urandom_range(0, live_q.size() - 1)]);
      end else if (pick < 86 && freed_q.size() != 0) begin
        push_release(freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else if (pick < 91) begin
        push_alloc($urandom_range(0, 1) ? 0 : 4095);
      end else begin
        push_release($urandom_range(0, 4095));
      end
    end

    // Wait for every word to be taken and every reply to come back.
    while (stim_q.size() != 0 || in_valid) @(negedge clk_i);
    while (reply_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
